@@ hdl/integer_sqrt_64_assert.svh @@
// Assertion macros shared by the integer square root block.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef INTEGER_SQRT_64_ASSERT_SVH
`define INTEGER_SQRT_64_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent is a sequence that starts in the cycle of the antecedent.
`define ISQ_ASSERT_SEQ(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

`endif

@@ hdl/isq_pkg.sv @@
package isq_pkg;

	// Width of the radicand bus and of the internal remainder and root words.
	localparam int unsigned DATA_W = 64;
	// Width of the root result.
	localparam int unsigned ROOT_W = 32;
	// Number of radicand bits that take part in the root.
	localparam int unsigned IN_WIDTH = 64;

	// Shift of the first trial bit: the highest power of four within IN_WIDTH bits.
	localparam int unsigned TOP_SHIFT = (IN_WIDTH - 1) & ~32'd1;
	// One cell for each power of four from the top down to one.
	localparam int unsigned NUM_STEPS = TOP_SHIFT / 2 + 1;

	// Radicand bits at or above IN_WIDTH are dropped.
	localparam logic [DATA_W-1:0] IN_MASK = {DATA_W{1'b1}} >> (DATA_W - IN_WIDTH);

	// Working state that moves from one cell to the next.
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] acc;
	} stage_t;

endpackage

@@ hdl/isq_cell.sv @@
module isq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  isq_pkg::stage_t               in_data,
	input  logic [isq_pkg::DATA_W-1:0]    trial,
	output logic                          out_valid,
	output isq_pkg::stage_t               out_data
);

	logic [isq_pkg::DATA_W-1:0] cand;
	logic                       take;
	isq_pkg::stage_t            next_data;
	logic                       valid_s1;
	isq_pkg::stage_t            data_s1;

	// One restoring step: subtract the candidate when it fits and set the root bit.
	always_comb begin
		cand          = in_data.acc + trial;
		take          = (in_data.rem >= cand);
		next_data.rem = take ? (in_data.rem - cand) : in_data.rem;
		next_data.acc = (in_data.acc >> 1) + (take ? trial : '0);
	end

	// The valid flag is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// The working data needs no reset.
	always_ff @(posedge clk) begin
		data_s1 <= next_data;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

@@ hdl/integer_sqrt_64.sv @@
// Floor square root of an unsigned 64-bit radicand.
//
// Input channel: drive radicand and raise start for one cycle. The item is
// taken at the rising edge where start is high and busy is low. busy is always
// low, so an item may be taken in every cycle.
//
// Result channel: root is valid for exactly one cycle while done is high. The
// receiver cannot hold results back; results leave in the order the items came.
//
// The restoring chain has one registered cell for each power of four, and the
// result leaves the last cell's register. Throughput is one item per cycle,
// set by the combinational subtract-and-compare in each cell.
//
// Reset: arst_n clears all valid flags at once, and items in flight are dropped.
// There is no clearing pass, and an item may be given in the first cycle after
// reset is released.
`include "integer_sqrt_64_assert.svh"

module integer_sqrt_64 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [isq_pkg::DATA_W-1:0]    radicand,
	output logic                          done,
	output logic [isq_pkg::ROOT_W-1:0]    root
);

	logic                        valid_chain [isq_pkg::NUM_STEPS+1];
	isq_pkg::stage_t             data_chain  [isq_pkg::NUM_STEPS+1];
	logic [isq_pkg::DATA_W-1:0]  rad_masked;
	logic [65:0]                 rad_ext;
	logic [65:0]                 root_sq;
	logic [65:0]                 next_sq;

	// The chain never stalls, so it can always take an item.
	assign busy = 1'b0;

	// Chain entry: the masked radicand as remainder, and an empty root.
	assign rad_masked         = radicand & isq_pkg::IN_MASK;
	assign valid_chain[0]     = start && !busy;
	assign data_chain[0].rem  = rad_masked;
	assign data_chain[0].acc  = '0;

	// One cell for each trial bit, from the top power of four down to one.
	for (genvar k = 0; k < isq_pkg::NUM_STEPS; k++) begin : g_cell
		localparam int unsigned SH = isq_pkg::TOP_SHIFT - 2 * k;
		localparam logic [isq_pkg::DATA_W-1:0] TRIAL =
			{{(isq_pkg::DATA_W-1){1'b0}}, 1'b1} << SH;

		isq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_chain[k]),
			.in_data   (data_chain[k]),
			.trial     (TRIAL),
			.out_valid (valid_chain[k+1]),
			.out_data  (data_chain[k+1])
		);
	end

	// The last cell's register is the result register.
	assign done = valid_chain[isq_pkg::NUM_STEPS];
	assign root = data_chain[isq_pkg::NUM_STEPS].acc[isq_pkg::ROOT_W-1:0];

	// Widened terms for the range checks on the root.
	assign rad_ext = {2'd0, rad_masked};
	assign root_sq = {34'd0, root} * {34'd0, root};
	assign next_sq = root_sq + {33'd0, root, 1'b0} + 66'd1;

	// Every item taken comes out of the last cell with done high.
	`ISQ_ASSERT_SEQ(a_item_latency, start && !busy, ##(isq_pkg::NUM_STEPS) done, "late item")

	// A result only appears for an item that was taken.
	`ISQ_ASSERT_SAME(a_no_spurious, done, $past(start && !busy, isq_pkg::NUM_STEPS), "no item")

	// The root squared does not exceed the radicand.
	`ISQ_ASSERT_SAME(a_root_low, done, root_sq <= $past(rad_ext, isq_pkg::NUM_STEPS), "too large")

	// The next integer squared exceeds the radicand.
	`ISQ_ASSERT_SAME(a_root_high, done, next_sq > $past(rad_ext, isq_pkg::NUM_STEPS), "too small")

endmodule

@@ bench/integer_sqrt_64_tb.sv @@
`timescale 1ns / 1ps

module integer_sqrt_64_tb;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = isq_pkg::NUM_STEPS + 16;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [isq_pkg::DATA_W-1:0] radicand;
	logic done;
	logic [isq_pkg::ROOT_W-1:0] root;

	// Roots still owed by the block, oldest first.
	logic [isq_pkg::ROOT_W-1:0] pending_roots[$];
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	integer_sqrt_64 u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.radicand(radicand),
		.done(done),
		.root(root)
	);

	always #5 clk = ~clk;

	// Restoring digit-by-digit square root with a 64-bit partial root.
	function automatic logic [isq_pkg::ROOT_W-1:0] floor_root(input logic [63:0] value);
		logic [63:0] rem;
		logic [63:0] acc;
		logic [63:0] trial;
		logic [63:0] cand;
		int unsigned top;
		rem = value & ({64{1'b1}} >> (64 - isq_pkg::IN_WIDTH));
		acc = '0;
		top = (isq_pkg::IN_WIDTH - 1) & ~32'd1;
		trial = 64'd1 << top;
		while (trial != 0) begin
			cand = acc + trial;
			if (rem >= cand) begin
				rem = rem - cand;
				acc = (acc >> 1) + trial;
			end else begin
				acc = acc >> 1;
			end
			trial = trial >> 2;
		end
		return acc[isq_pkg::ROOT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// Check each result against the oldest prediction, then record any item
	// taken at this edge. One process keeps the order fixed within a step.
	always @(posedge clk) begin
		if (arst_n) begin
			if ($isunknown(done)) begin
				report_mismatch("done is unknown", 64'd0, 64'd0);
			end else if (done) begin
				if (pending_roots.size() == 0) begin
					report_mismatch("result with no item pending", 64'd0, {32'd0, root});
				end else if (root !== pending_roots[0]) begin
					report_mismatch("root", {32'd0, pending_roots[0]}, {32'd0, root});
					void'(pending_roots.pop_front());
				end else begin
					void'(pending_roots.pop_front());
				end
			end
			if (start && !busy)
				pending_roots.push_back(floor_root(radicand));
			if ((start && !busy) || done === 1'b1)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d items pending", $realtime,
					pending_roots.size());
				$display("integer_sqrt_64_tb failed");
				$finish;
			end
		end
	end

	// Present one item and return at the edge that takes it. start stays high,
	// so a following item goes out back to back.
	task automatic send_radicand(input logic [63:0] value);
		start <= 1'b1;
		radicand <= value;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles; the bus carries junk meanwhile.
	task automatic idle_cycles(input int unsigned count);
		if (count != 0) begin
			start <= 1'b0;
			radicand <= {$urandom, $urandom};
			repeat (count) @(posedge clk);
		end
	endtask

	task automatic wait_until_drained();
		while (pending_roots.size() != 0)
			@(posedge clk);
	endtask

	// Mixed radicand shapes: uniform, short, near perfect squares, top range, tiny.
	function automatic logic [63:0] pick_radicand();
		logic [63:0] value;
		logic [63:0] r;
		case ($urandom_range(0, 5))
			0, 1: value = {$urandom, $urandom};
			2: value = {$urandom, $urandom} >> $urandom_range(0, 63);
			3: begin
				r = {32'd0, $urandom};
				case ($urandom_range(0, 2))
					0: value = r * r - 64'd1;
					1: value = r * r;
					default: value = r * r + 2 * r;
				endcase
			end
			4: value = {32'hFFFF_FFFF, $urandom} | (64'd1 << $urandom_range(0, 63));
			default: value = 64'($urandom_range(0, 1023));
		endcase
		return value;
	endfunction

	// Zero, one, the top of the range and the edges of the largest squares.
	task automatic test_corner_values();
		logic [63:0] corners[$];
		corners = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9, 64'd15, 64'd16,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
			64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
			64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, 64'h0000_0001_0000_0000,
			64'h0000_0000_FFFF_FFFF};
		foreach (corners[i])
			send_radicand(corners[i]);
		idle_cycles(3);
	endtask

	// Random roots with their square, the value just under it and the largest
	// value that still has the same root, sent back to back.
	task automatic test_square_edges(input int unsigned count);
		logic [63:0] r;
		repeat (count) begin
			r = {32'd0, $urandom};
			send_radicand(r * r);
			send_radicand(r * r - 64'd1);
			send_radicand(r * r + 2 * r);
		end
	endtask

	// Bursts of random length with random gaps, and now and then a long run.
	task automatic test_random_bursts(input int unsigned count);
		int unsigned sent;
		int unsigned burst;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			repeat (burst) begin
				send_radicand(pick_radicand());
				if ($urandom_range(0, 5) == 0)
					idle_cycles($urandom_range(1, 3));
			end
			sent += burst;
			idle_cycles($urandom_range(0, 20));
		end
	endtask

	// Let the pipeline empty completely, then restart from idle.
	task automatic test_drain_pause();
		idle_cycles(1);
		wait_until_drained();
		idle_cycles($urandom_range(0, 5));
		send_radicand(64'hFFFF_FFFF_FFFF_FFFF);
		send_radicand(64'd0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		radicand = '0;
		mismatch_count = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_square_edges(50);
		test_random_bursts(500);
		test_drain_pause();
		test_random_bursts(500);
		test_drain_pause();

		// Wait for the last roots, then give a stray result time to show up.
		idle_cycles(1);
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("integer_sqrt_64_tb passed");
		else
			$display("integer_sqrt_64_tb failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/isq_pkg.sv
hdl/isq_cell.sv
hdl/integer_sqrt_64.sv
bench/integer_sqrt_64_tb.sv
